@@ rtl/core/rucwrc_pkg.sv @@
// Package for the RoCE UC write receive checker: request and result types,
// opcode, status and register codes, and sizing constants. No dependencies.
package rucwrc_pkg;

    localparam int unsigned SEQ_W        = 24;
    localparam int unsigned PAGE_W       = 12;
    localparam int unsigned DIVIDEND_W   = 48;
    localparam int unsigned DIVISOR_W    = 32;
    localparam int unsigned MOD_BITS     = 3;
    localparam int unsigned MOD_STEPS    = DIVIDEND_W / MOD_BITS;
    localparam int unsigned MOD_STEP_W   = $clog2(MOD_STEPS);
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = 64;

    localparam logic [7:0]  OP_WRITE_ONLY    = 8'h2A;
    localparam logic [7:0]  OP_WRITE_IMM     = 8'h2B;
    localparam logic [16:0] HDR_WRITE        = 17'd28;
    localparam logic [16:0] HDR_IMM          = 17'd32;
    localparam logic [15:0] METADATA_BYTES   = 16'd128;
    localparam logic [16:0] MAX_PACKET_BYTES = 17'd9216;
    localparam logic [31:0] PAGE_BYTES_RESET = 32'd65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BUFFER_BASE    = 3'd0,
        CFG_BUFFER_BYTES   = 3'd1,
        CFG_PAGE_BYTES     = 3'd2,
        CFG_ADDRESS_OFFSET = 3'd3,
        CFG_PAGE_COUNT     = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_RUNT       = 3'd0,
        ST_WRITTEN    = 3'd1,
        ST_OUT_RANGE  = 3'd2,
        ST_SPANS_PAGE = 3'd3,
        ST_FRAME_DONE = 3'd4,
        ST_BAD_META   = 3'd5,
        ST_UNKNOWN_OP = 3'd6,
        ST_BAD_PAGE   = 3'd7
    } t_status;

    // Classification handed from front to back
    typedef enum logic [2:0] {
        K_RUNT,
        K_WRITE,
        K_OUT_RANGE,
        K_IMM_BAD_SIZE,
        K_IMM_BAD_PAGE,
        K_IMM_OK,
        K_UNKNOWN
    } t_kind;

    typedef struct packed {
        logic [63:0] buffer_base;
        logic [47:0] buffer_bytes;
        logic [31:0] page_bytes;
        logic [63:0] address_offset;
        logic [12:0] page_count;
    } t_cfg;

    typedef struct packed {
        logic        base_header_ok;
        logic [7:0]  opcode;
        logic [23:0] seq_number;
        logic        ext_header_ok;
        logic [63:0] remote_address;
        logic [15:0] payload_bytes;
        logic [31:0] immediate;
        logic [63:0] arrival_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] write_offset;
        logic [15:0] write_length;
        logic [31:0] frame_packets;
        logic [31:0] frame_bytes;
        logic [31:0] frames_seen;
        logic [63:0] dropped_total;
        logic [63:0] start_time;
        logic [63:0] end_time;
        logic [11:0] page_index;
        logic [31:0] immediate_out;
    } t_out_item;

    typedef struct packed {
        t_kind                   kind;
        logic                    has_seq;
        logic [SEQ_W-1:0]        seq;
        logic [DIVIDEND_W-1:0]   diff;
        logic [15:0]             size;
        logic [31:0]             imm;
        logic [63:0]             now;
    } t_cmd;

endpackage

@@ rtl/core/rucwrc_front.sv @@
// Front end: accepts one request, adds the address offset, bounds-checks the
// target and classifies the opcode. Depends on rucwrc_pkg.
module rucwrc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rucwrc_pkg::t_cfg    i_cfg,
    input  logic                i_push,
    input  rucwrc_pkg::t_in_item i_item,
    output logic                o_full,
    output logic                o_cmd_push,
    output rucwrc_pkg::t_cmd    o_cmd,
    input  logic                i_cmd_full
);
    import rucwrc_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_ADD  = 4'b0010,
        F_CHK  = 4'b0100,
        F_CLS  = 4'b1000
    } t_fstate;

    t_fstate     r_state, n_state;
    t_in_item    r_in;
    logic [63:0] r_target;
    logic [63:0] r_diff;
    logic        r_ge;

    logic        is_wr, is_imm, in_range, bad_page;
    t_kind       kind;

    always_comb begin
        is_wr  = r_in.opcode == OP_WRITE_ONLY && r_in.ext_header_ok &&
                 ({1'b0, r_in.payload_bytes} + HDR_WRITE) <= MAX_PACKET_BYTES;
        is_imm = r_in.opcode == OP_WRITE_IMM && r_in.ext_header_ok &&
                 ({1'b0, r_in.payload_bytes} + HDR_IMM) <= MAX_PACKET_BYTES;
        in_range = r_ge && (r_diff <= {16'd0, i_cfg.buffer_bytes}) &&
                   ({32'd0, r_in.payload_bytes} <= (i_cfg.buffer_bytes - r_diff[47:0]));
        bad_page = {1'b0, r_in.immediate[PAGE_W-1:0]} >= i_cfg.page_count;
        if (!r_in.base_header_ok) begin
            kind = K_RUNT;
        end else if (is_wr) begin
            kind = in_range ? K_WRITE : K_OUT_RANGE;
        end else if (is_imm) begin
            if (r_in.payload_bytes != METADATA_BYTES) begin
                kind = K_IMM_BAD_SIZE;
            end else begin
                kind = bad_page ? K_IMM_BAD_PAGE : K_IMM_OK;
            end
        end else begin
            kind = K_UNKNOWN;
        end
    end

    always_comb begin
        o_cmd.kind    = kind;
        o_cmd.has_seq = r_in.base_header_ok;
        o_cmd.seq     = r_in.seq_number;
        o_cmd.diff    = r_diff[DIVIDEND_W-1:0];
        o_cmd.size    = r_in.payload_bytes;
        o_cmd.imm     = r_in.immediate;
        o_cmd.now     = r_in.arrival_time;
    end

    assign o_full     = (r_state != F_IDLE);
    assign o_cmd_push = (r_state == F_CLS) && !i_cmd_full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_push) n_state = F_ADD;
            F_ADD:   n_state = F_CHK;
            F_CHK:   n_state = F_CLS;
            F_CLS:   if (!i_cmd_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: the offset add is registered in F_ADD, the bounds subtract and compare in F_CHK
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            r_in <= i_item;
        end
        if (r_state == F_ADD) begin
            r_target <= r_in.remote_address + i_cfg.address_offset;
        end
        if (r_state == F_CHK) begin
            r_diff <= r_target - i_cfg.buffer_base;
            r_ge   <= r_target >= i_cfg.buffer_base;
        end
    end

endmodule

@@ rtl/core/rucwrc_queue.sv @@
// Two-entry queue of classified commands between front and back.
// Depends on rucwrc_pkg.
module rucwrc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rucwrc_pkg::t_cmd i_data,
    output logic             o_full,
    input  logic             i_pop,
    output rucwrc_pkg::t_cmd o_data,
    output logic             o_empty
);
    import rucwrc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/core/rucwrc_mod.sv @@
// Iterative remainder unit: a 48-bit offset modulo a 32-bit page size,
// three quotient bits per cycle. Depends on rucwrc_pkg.
module rucwrc_mod (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rucwrc_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [rucwrc_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic [rucwrc_pkg::DIVISOR_W-1:0]  o_rem
);
    import rucwrc_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [MOD_STEP_W-1:0]  r_step;
    logic [DIVIDEND_W-1:0]  r_shift;
    logic [DIVISOR_W-1:0]   r_rem;
    logic [DIVISOR_W-1:0]   n_rem;

    // Restoring steps: remainder stays below the divisor after each one
    always_comb begin
        logic [DIVISOR_W:0] trial;
        n_rem = r_rem;
        for (int b = 0; b < MOD_BITS; b++) begin
            trial = {n_rem, r_shift[DIVIDEND_W-1-b]};
            if (trial >= {1'b0, i_divisor}) begin
                trial = trial - {1'b0, i_divisor};
            end
            n_rem = trial[DIVISOR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == MOD_STEP_W'(MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= r_shift << MOD_BITS;
            r_rem   <= n_rem;
        end
    end

endmodule

@@ rtl/core/rucwrc_back.sv @@
// Back end: carries out classified commands in order, keeps the sequence,
// packet and frame counters and holds the result register.
// Depends on rucwrc_pkg and rucwrc_mod.
module rucwrc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_page_bytes,
    input  rucwrc_pkg::t_cmd      i_cmd,
    input  logic                  i_cmd_empty,
    output logic                  o_cmd_pop,
    output logic                  o_empty,
    input  logic                  i_pop,
    output rucwrc_pkg::t_out_item o_result
);
    import rucwrc_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_FIN  = 3'b100
    } t_bstate;

    t_bstate     r_state, n_state;
    t_cmd        r_cmd;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [23:0] r_last_seq;
    logic        r_seq_seen;
    logic [63:0] r_dropped;
    logic [31:0] r_packet_count;
    logic [31:0] r_byte_count;
    logic [31:0] r_frame_total;
    logic [63:0] r_frame_start;

    logic [63:0] n_dropped;
    logic [31:0] n_packet_count;
    logic [31:0] n_byte_count;
    logic [31:0] n_frame_total;
    logic [63:0] n_frame_start;
    t_out_item   res;

    logic        need_mod;
    logic        mod_start;
    logic        mod_done;
    logic [31:0] mod_rem;
    logic        slot_free;
    logic        commit;

    assign need_mod  = (i_cmd.kind == K_WRITE) && (i_page_bytes != 32'd0);
    assign o_cmd_pop = (r_state == B_IDLE) && !i_cmd_empty;
    assign mod_start = o_cmd_pop && need_mod;
    assign slot_free = !r_out_valid || i_pop;
    assign commit    = (r_state == B_FIN) && slot_free;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    rucwrc_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_cmd.diff),
        .i_divisor  (i_page_bytes),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_comb begin
        logic [23:0] gap;
        logic        fits;
        gap  = r_cmd.seq - r_last_seq - 24'd1;
        fits = ({1'b0, mod_rem} + {17'd0, r_cmd.size}) <= {1'b0, i_page_bytes};

        n_packet_count = r_packet_count + 32'd1;
        n_byte_count   = r_byte_count;
        n_frame_total  = r_frame_total;
        n_frame_start  = (r_byte_count == 32'd0) ? r_cmd.now : r_frame_start;
        n_dropped      = r_dropped;
        if (r_cmd.has_seq && r_seq_seen) begin
            n_dropped = r_dropped + {40'd0, gap};
        end

        res = '0;
        case (r_cmd.kind)
            K_RUNT:      res.status = ST_RUNT;
            K_OUT_RANGE: res.status = ST_OUT_RANGE;
            K_WRITE: begin
                if (i_page_bytes == 32'd0 || !fits) begin
                    res.status = ST_SPANS_PAGE;
                end else begin
                    res.status       = ST_WRITTEN;
                    res.write_offset = mod_rem;
                    res.write_length = r_cmd.size;
                    n_byte_count     = r_byte_count + {16'd0, r_cmd.size};
                end
            end
            K_IMM_BAD_SIZE: begin
                n_frame_total = r_frame_total + 32'd1;
                res.status    = ST_BAD_META;
            end
            K_IMM_BAD_PAGE: begin
                n_frame_total     = r_frame_total + 32'd1;
                res.status        = ST_BAD_PAGE;
                res.page_index    = r_cmd.imm[PAGE_W-1:0];
                res.immediate_out = r_cmd.imm;
            end
            K_IMM_OK: begin
                n_frame_total     = r_frame_total + 32'd1;
                res.status        = ST_FRAME_DONE;
                res.frame_packets = n_packet_count;
                res.frame_bytes   = r_byte_count;
                res.start_time    = n_frame_start;
                res.end_time      = r_cmd.now;
                res.page_index    = r_cmd.imm[PAGE_W-1:0];
                res.immediate_out = r_cmd.imm;
                n_packet_count    = 32'd0;
                n_byte_count      = 32'd0;
            end
            default:     res.status = ST_UNKNOWN_OP;
        endcase
        res.frames_seen   = n_frame_total;
        res.dropped_total = n_dropped;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_cmd_empty) n_state = need_mod ? B_DIV : B_FIN;
            B_DIV:   if (mod_done) n_state = B_FIN;
            B_FIN:   if (slot_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= B_IDLE;
            r_out_valid    <= 1'b0;
            r_last_seq     <= '0;
            r_seq_seen     <= 1'b0;
            r_dropped      <= '0;
            r_packet_count <= '0;
            r_byte_count   <= '0;
            r_frame_total  <= '0;
            r_frame_start  <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid    <= 1'b1;
                r_dropped      <= n_dropped;
                r_packet_count <= n_packet_count;
                r_byte_count   <= n_byte_count;
                r_frame_total  <= n_frame_total;
                r_frame_start  <= n_frame_start;
                if (r_cmd.has_seq) begin
                    r_last_seq <= r_cmd.seq;
                    r_seq_seen <= 1'b1;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= i_cmd;
        if (commit)    r_out <= res;
    end

endmodule

@@ rtl/core/roce_uc_write_receive_checker.sv @@
// Top level of the RoCE UC write receive checker: configuration registers,
// front end, command queue and back end. Depends on rucwrc_pkg and submodules.
//
// Usage
//   Requests: drive one pre-split packet header on i_item with push; it is
//   taken on a rising edge where push is high and full is low.
//   Results: one result per request, in order. While empty is low the oldest
//   result sits on o_result; pop takes it on an edge where empty is low.
//   Configuration: i_cfg_we writes i_cfg_data to the register named by
//   i_cfg_index at once; indexes past the list are ignored. Write only while
//   the block has no request in flight.
// Flow
//   The front end takes a request, then adds the offset, subtracts for the
//   bounds check, classifies and hands over, waiting while the queue is full.
//   It takes no new request until it has handed the last one over. The back
//   end pops a command and commits its result; an in-range write with a nonzero
//   page size first runs sixteen steps of the iterative remainder unit (three
//   bits a cycle over 48 bits).
// Reset and stalls
//   Reset clears all counters and the queue; page size comes back as 65536.
//   No clearing pass is needed. A stalled receiver holds the result register;
//   the back end then stops at its commit step, the two-entry queue fills and
//   full rises, while no request is lost.
module roce_uc_write_receive_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    input  rucwrc_pkg::t_in_item                   i_item,
    output logic                                   full,
    output logic                                   empty,
    input  logic                                   pop,
    output rucwrc_pkg::t_out_item                  o_result,
    input  logic                                   i_cfg_we,
    input  logic [rucwrc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [rucwrc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import rucwrc_pkg::*;

    t_cfg r_cfg;

    logic cmd_push, cmd_full, cmd_pop, cmd_empty;
    t_cmd cmd_in, cmd_out;

    // Hold configuration; narrow registers keep only their low bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_base    <= '0;
            r_cfg.buffer_bytes   <= '0;
            r_cfg.page_bytes     <= PAGE_BYTES_RESET;
            r_cfg.address_offset <= '0;
            r_cfg.page_count     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BUFFER_BASE:    r_cfg.buffer_base    <= i_cfg_data;
                CFG_BUFFER_BYTES:   r_cfg.buffer_bytes   <= i_cfg_data[47:0];
                CFG_PAGE_BYTES:     r_cfg.page_bytes     <= i_cfg_data[31:0];
                CFG_ADDRESS_OFFSET: r_cfg.address_offset <= i_cfg_data;
                CFG_PAGE_COUNT:     r_cfg.page_count     <= i_cfg_data[12:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    // Classify each request
    rucwrc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    // Decouple front from back
    rucwrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    // Advance counters and deliver results
    rucwrc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_page_bytes (r_cfg.page_bytes),
        .i_cmd        (cmd_out),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (o_result)
    );

endmodule

@@ rtl/core/rucwrc_checker.sv @@
// Port-level assertions for the write receive checker, bound to the top level.
// Depends on rucwrc_pkg and roce_uc_write_receive_checker.
module rucwrc_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic                  empty,
    input  logic                  pop,
    input  rucwrc_pkg::t_out_item o_result
);
    import rucwrc_pkg::*;

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // A waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

    // Write fields only on a written result
    a_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status != ST_WRITTEN) |->
        (o_result.write_offset == 32'd0 && o_result.write_length == 16'd0))
        else $error("write fields set on a non-write result");

    // Frame statistics only on a closed frame
    a_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status != ST_FRAME_DONE) |->
        (o_result.frame_packets == 32'd0 && o_result.start_time == 64'd0 &&
         o_result.end_time == 64'd0))
        else $error("frame fields set on an open frame");

endmodule

bind roce_uc_write_receive_checker rucwrc_checker u_rucwrc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
